// ===== hdl/tbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsd_pkg
// Shared types and constants for the byte-string deframer.
// ----------------------------------------------------------------------------
package tbsd_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Marker value that announces a three-byte little-endian length.
    localparam logic [BYTE_W-1:0] LONG_MARKER = 8'd254;

    // One classified input beat as it sits in the front-to-back queue.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              long_mark;  // byte equals the long-form marker
        logic [1:0]        short_pad;  // padding owed if this byte is a short marker
    } cls_t;

endpackage

// ===== hdl/tl_byte_string_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tl_byte_string_deframer_core
// Splits a byte stream into length-prefixed byte-string fields.
// ----------------------------------------------------------------------------
// The slave channel takes one buffer byte per beat; s_tlast marks the final
// byte of a buffer. The master channel returns exactly one result beat for
// every input beat, in order. Each result says whether the byte was payload
// (passed on in the low byte of m_tdata), whether it closed a field (with the
// field's payload length), or whether the buffer ended inside a field.
// Payload bytes are forwarded as they arrive, before the field is known to
// be complete, so a consumer must honor the truncated flag.
// Throughput is one beat per cycle: the parser updates its state once per
// byte, so a new beat is taken every cycle while results drain.
// An accepted input beat is registered in the classification queue and then,
// once the parser takes it, in the parser's result register.
// A small queue between the classifier and the parser lets the input keep
// flowing for a few beats while m_tready is low; once it fills, s_tready
// drops until the receiver takes results again. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and returns the parser to expecting a marker byte.
// ----------------------------------------------------------------------------
module tl_byte_string_deframer_core
    import tbsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Input byte stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // last_in_buffer
    // Result stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] out_byte, [31:8] field_length
    output logic [2:0]        m_tuser    // [0] payload_valid, [1] field_done,
                                         // [2] truncated
);

    // Queue handshake between the front and the parser.
    logic q_valid;
    logic q_ready;
    cls_t q_item;

    // The front tags each byte (long marker, short-form padding) and queues it.
    tbsd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // The back runs the field state machine and owns the result register.
    tbsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // A byte cannot both close a field and report a truncated field.
    a_done_excl_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("field_done and truncated on the same beat");

    // The length is reported only on the beat that closes a field.
    a_len_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[31:8] == '0))
        else $error("field_length nonzero without field_done");

    // Non-payload beats carry a zero data byte.
    a_byte_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == '0))
        else $error("out_byte nonzero without payload_valid");

    // A result can only appear after the queue has offered a beat.
    a_result_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_valid))
        else $error("result beat without a queued input beat");
`endif

endmodule

// ===== hdl/tbsd_front.sv =====
// ----------------------------------------------------------------------------
// tbsd_front
// Accepts input beats, tags marker properties, and holds them in a queue.
// ----------------------------------------------------------------------------
module tbsd_front
    import tbsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              q_valid,
    input  logic              q_ready,
    output cls_t              q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cls_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cls_t             cls;
    logic             push;
    logic             pop;

    // Classification: the short-form padding is (3 - len) mod 4.
    always_comb begin
        cls.data      = s_tdata;
        cls.last      = s_tlast;
        cls.long_mark = (s_tdata == LONG_MARKER);
        cls.short_pad = ~s_tdata[1:0];
    end

    assign s_tready = (count_reg != FULL_CNT);
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hdl/tbsd_back.sv =====
// ----------------------------------------------------------------------------
// tbsd_back
// Field parser state machine with a registered result stage.
// ----------------------------------------------------------------------------
module tbsd_back
    import tbsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  cls_t              q_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [2:0]        m_tuser
);

    localparam logic [1:0] PH_MARKER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_PAD     = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [1:0]        lbs_reg, lbs_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [1:0]        align_reg, align_next;

    logic              valid_reg;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              pvalid_reg, pvalid_next;
    logic              done_reg, done_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic              trunc_reg, trunc_next;

    logic              pop;
    logic [1:0]        pad;
    logic [LEN_W-1:0]  rem_dec;
    logic [BYTE_W-1:0] b;

    assign q_ready = !valid_reg || m_tready;
    assign pop     = q_valid && q_ready;
    assign b       = q_item.data;
    assign rem_dec = rem_reg - 1'b1;

    always_comb begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        lbs_next    = lbs_reg;
        rem_next    = rem_reg;
        align_next  = align_reg;
        pvalid_next = 1'b0;
        obyte_next  = '0;
        done_next   = 1'b0;
        trunc_next  = 1'b0;
        pad         = 2'd0;

        unique case (phase_reg)
            PH_MARKER: begin
                if (q_item.long_mark) begin
                    len_next   = '0;
                    lbs_next   = 2'd0;
                    phase_next = PH_LENGTH;
                end else begin
                    len_next = {{(LEN_W-BYTE_W){1'b0}}, b};
                    pad      = q_item.short_pad;
                end
            end
            PH_LENGTH: begin
                case (lbs_reg)
                    2'd0:    len_next = {len_reg[23:8], len_reg[7:0] | b};
                    2'd1:    len_next = {len_reg[23:16], len_reg[15:8] | b, len_reg[7:0]};
                    2'd2:    len_next = {len_reg[23:16] | b, len_reg[15:0]};
                    default: len_next = len_reg;
                endcase
                lbs_next = lbs_reg + 2'd1;
                if (lbs_reg == 2'd2) begin
                    lbs_next = 2'd0;
                    // Four-byte prefix: padding is (-len) mod 4.
                    pad      = ~len_next[1:0] + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                obyte_next  = b;
                pvalid_next = 1'b1;
                rem_next    = rem_dec;
                if (rem_dec == '0) begin
                    if (align_reg != 2'd0) begin
                        phase_next = PH_PAD;
                    end else begin
                        phase_next = PH_MARKER;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_PAD: begin
                align_next = align_reg - 2'd1;
                if (align_next == 2'd0) begin
                    phase_next = PH_MARKER;
                    done_next  = 1'b1;
                end
            end
            default: begin
                phase_next = PH_MARKER;
            end
        endcase

        // Length just became known: start the body of the field.
        if ((phase_reg == PH_MARKER && !q_item.long_mark) ||
            (phase_reg == PH_LENGTH && lbs_reg == 2'd2)) begin
            align_next = pad;
            rem_next   = len_next;
            if (len_next != '0) begin
                phase_next = PH_PAYLOAD;
            end else if (pad != 2'd0) begin
                phase_next = PH_PAD;
            end else begin
                phase_next = PH_MARKER;
                done_next  = 1'b1;
            end
        end

        // Buffer ended inside an unfinished field.
        if (q_item.last && !done_next) begin
            trunc_next = 1'b1;
            phase_next = PH_MARKER;
            lbs_next   = 2'd0;
            rem_next   = '0;
            align_next = 2'd0;
        end

        flen_next = done_next ? len_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MARKER;
            len_reg   <= '0;
            lbs_reg   <= 2'd0;
            rem_reg   <= '0;
            align_reg <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                lbs_reg   <= lbs_next;
                rem_reg   <= rem_next;
                align_reg <= align_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            obyte_reg  <= obyte_next;
            pvalid_reg <= pvalid_next;
            done_reg   <= done_next;
            flen_reg   <= flen_next;
            trunc_reg  <= trunc_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {flen_reg, obyte_reg};
    assign m_tuser  = {trunc_reg, done_reg, pvalid_reg};

endmodule

// ===== bench/tb_tl_byte_string_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_tl_byte_string_deframer_core
// Self-checking bench for the byte-string deframer core.
// ----------------------------------------------------------------------------
// A short directed sequence covers zero-length fields in both length forms,
// a marker of 255, padding, and buffers that end on a marker, inside a
// length, inside a payload or exactly at a field end. Random buffers of
// well-formed fields follow, mixed with truncated buffers, buffers that run
// into the next one and plain noise. Every accepted input beat is fed to a
// field-splitting predictor. Every result beat is checked field by field
// against the oldest prediction. Both channels idle at random, and once the
// receiver holds off long enough for the core to back up and stall its input.
// ----------------------------------------------------------------------------
module tb_tl_byte_string_deframer_core;
    import tbsd_pkg::*;

    localparam int          ALIGN_BYTES     = 4;
    localparam int          LONG_LEN_BYTES  = 3;
    localparam int          STREAM_TARGET   = 1350;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          HOLD_OFF_AT     = 300;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int unsigned LIMIT_CYCLES    = 400000;

    // Directed beats, bit 8 is the buffer-end flag and bits 7:0 the byte.
    localparam logic [8:0] DIRECTED_BEATS [26] = '{
        // Short marker 0: no payload, three padding bytes close the field.
        9'h000, 9'h0AA, 9'h055, 9'h0FF,
        // Long form with a length of 0: the field ends on the third length byte.
        9'h0FE, 9'h000, 9'h000, 9'h000,
        // Long form with a length of 1: one payload byte, then three pads.
        9'h0FE, 9'h001, 9'h000, 9'h000, 9'h07F, 9'h011, 9'h022, 9'h033,
        // Marker 255 is a plain length; the buffer ends on a payload byte.
        9'h0FF, 9'h012, 9'h134,
        // The buffer ends exactly where the field ends.
        9'h002, 9'h0AB, 9'h0CD, 9'h1EE,
        // The buffer ends on a marker byte.
        9'h105,
        // The buffer ends inside a long-form length.
        9'h0FE, 9'h110
    };

    typedef enum logic [1:0] {
        WAIT_MARKER,
        WAIT_LENGTH,
        IN_PAYLOAD,
        IN_PADDING
    } parse_phase_e;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              payload_valid;
        logic              field_done;
        logic [LEN_W-1:0]  field_length;
        logic              truncated;
    } split_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } stream_beat_t;

    // Predicts one result per input byte and checks the core's results in order.
    class field_split_predictor;
        parse_phase_e     phase        = WAIT_MARKER;
        logic [LEN_W-1:0] length_value = '0;
        logic [1:0]       length_seen  = '0;
        logic [LEN_W-1:0] payload_left = '0;
        logic [1:0]       pad_left     = '0;
        split_result_t    pending_splits[$];
        int unsigned      failures     = 0;

        // The length is known: set up payload and padding. Returns 1 when the
        // field has neither and is therefore already complete.
        function bit start_body(int unsigned prefix);
            pad_left     = 2'(ALIGN_BYTES - ((prefix + length_value) % ALIGN_BYTES));
            payload_left = length_value;
            if (payload_left != 0) begin
                phase = IN_PAYLOAD;
                return 1'b0;
            end
            if (pad_left != 0) begin
                phase = IN_PADDING;
                return 1'b0;
            end
            phase = WAIT_MARKER;
            return 1'b1;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            split_result_t r;
            r = '0;
            case (phase)
                WAIT_MARKER: begin
                    if (b == LONG_MARKER) begin
                        length_value = '0;
                        length_seen  = '0;
                        phase        = WAIT_LENGTH;
                    end else begin
                        length_value = LEN_W'(b);
                        r.field_done = start_body(1);
                    end
                end
                WAIT_LENGTH: begin
                    length_value = length_value | (LEN_W'(b) << (8 * length_seen));
                    length_seen  = length_seen + 2'd1;
                    if (length_seen >= LONG_LEN_BYTES) begin
                        length_seen  = '0;
                        r.field_done = start_body(1 + LONG_LEN_BYTES);
                    end
                end
                IN_PAYLOAD: begin
                    r.out_byte      = b;
                    r.payload_valid = 1'b1;
                    payload_left    = payload_left - 1'b1;
                    if (payload_left == 0) begin
                        if (pad_left != 0) begin
                            phase = IN_PADDING;
                        end else begin
                            phase        = WAIT_MARKER;
                            r.field_done = 1'b1;
                        end
                    end
                end
                default: begin
                    pad_left = pad_left - 2'd1;
                    if (pad_left == 0) begin
                        phase        = WAIT_MARKER;
                        r.field_done = 1'b1;
                    end
                end
            endcase
            if (last && !r.field_done) begin
                r.truncated  = 1'b1;
                phase        = WAIT_MARKER;
                length_seen  = '0;
                payload_left = '0;
                pad_left     = '0;
            end
            if (r.field_done) begin
                r.field_length = length_value;
            end
            pending_splits.insert(pending_splits.size(), r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void match_result(logic [31:0] data, logic [2:0] flags);
            split_result_t want;
            if (pending_splits.size() == 0) begin
                failures++;
                $display("%0t: unexpected result beat: expected none, actual tdata=%h tuser=%b",
                         $time, data, flags);
                return;
            end
            want = pending_splits.pop_front();
            compare_field("out_byte",      want.out_byte,      data[7:0]);
            compare_field("field_length",  want.field_length,  data[31:8]);
            compare_field("payload_valid", want.payload_valid, flags[0]);
            compare_field("field_done",    want.field_done,    flags[1]);
            compare_field("truncated",     want.truncated,     flags[2]);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic [2:0]        m_tuser;

    field_split_predictor splitter = new();
    stream_beat_t         byte_stream[$];
    int unsigned          cycle_count = 0;

    tl_byte_string_deframer_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Appends one random buffer to the byte stream. Most buffers are runs of
    // well-formed fields; some are cut short, some carry a long-form header
    // with a random 24-bit length that the buffer end interrupts, some run
    // on into the next buffer without an end flag, and a few are noise.
    function automatic void add_random_buffer();
        logic [BYTE_W-1:0] pieces[$];
        int unsigned       mode;
        int unsigned       len;
        int unsigned       prefix;
        int unsigned       keep;
        stream_beat_t      beat;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            repeat ($urandom_range(1, 8)) pieces.insert(pieces.size(), BYTE_W'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                // Long payloads are rare so that the stream stays varied.
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 255)
                                                   : $urandom_range(0, 9);
                if (len == LONG_MARKER || $urandom_range(0, 3) == 0) begin
                    prefix = 1 + LONG_LEN_BYTES;
                    pieces.insert(pieces.size(), LONG_MARKER);
                    pieces.insert(pieces.size(), BYTE_W'(len));
                    pieces.insert(pieces.size(), BYTE_W'(len >> 8));
                    pieces.insert(pieces.size(), BYTE_W'(len >> 16));
                end else begin
                    prefix = 1;
                    pieces.insert(pieces.size(), BYTE_W'(len));
                end
                repeat (len) pieces.insert(pieces.size(), BYTE_W'($urandom));
                repeat ((ALIGN_BYTES - ((prefix + len) % ALIGN_BYTES)) % ALIGN_BYTES)
                    pieces.insert(pieces.size(), BYTE_W'($urandom));
            end
            if (mode == 1) begin
                pieces.insert(pieces.size(), LONG_MARKER);
                repeat ($urandom_range(3, 8)) pieces.insert(pieces.size(), BYTE_W'($urandom));
            end else if (mode == 2) begin
                keep = $urandom_range(1, pieces.size() - 1);
                while (pieces.size() > keep) void'(pieces.pop_back());
            end
        end
        foreach (pieces[i]) begin
            beat.data = pieces[i];
            beat.last = (mode != 3) && (i == pieces.size() - 1);
            byte_stream.insert(byte_stream.size(), beat);
        end
    endfunction

    // Offers the byte stream on the slave channel with random gaps and
    // occasional stretches without any.
    task automatic drive_bytes();
        int gap;
        bit quiet;
        quiet = 1'b0;
        foreach (byte_stream[i]) begin
            if (i % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= byte_stream[i].data;
            s_tlast  <= byte_stream[i].last;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            splitter.take_byte(byte_stream[i].data, byte_stream[i].last);
        end
        s_tvalid <= 1'b0;
    endtask

    // Takes result beats with random stalls. Once, the receiver holds off for
    // a long stretch so that the core's queue fills and s_tready drops.
    task automatic collect_results();
        int          gap;
        int unsigned taken;
        bit          quiet;
        taken = 0;
        quiet = 1'b0;
        forever begin
            if (taken % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 8);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            splitter.match_result(m_tdata, m_tuser);
            taken++;
        end
    endtask

    initial begin
        stream_beat_t beat;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;

        foreach (DIRECTED_BEATS[i]) begin
            beat.data = DIRECTED_BEATS[i][7:0];
            beat.last = DIRECTED_BEATS[i][8];
            byte_stream.insert(byte_stream.size(), beat);
        end
        while (byte_stream.size() < STREAM_TARGET) add_random_buffer();
        // A long final buffer may overshoot; cut the stream back to size.
        while (byte_stream.size() > STREAM_TARGET) void'(byte_stream.pop_back());

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            collect_results();
        join_none
        drive_bytes();

        // Let the last results drain, then keep watching for any stray beat.
        while (splitter.pending_splits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (splitter.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
